// ----- rtl/bellman_ford_shortest_paths_assert.svh -----
// Assertion macros for the shortest path engine
`ifndef BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define BFSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define BFSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bfsp_pkg.sv -----
`timescale 1ns / 1ps

package bfsp_pkg;

    localparam int VID_BITS  = 6;
    localparam int CFG_BITS  = 7;
    localparam int DIST_BITS = 32;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam logic [CFG_BITS-1:0] VCOUNT_RST = 7'd64;

    localparam logic signed [DIST_BITS-1:0] DIST_INF  = 32'sh7FFF_FFFF;
    localparam logic signed [DIST_BITS-1:0] DIST_TOP  = 32'sh7FFF_FFFE;
    localparam logic signed [DIST_BITS-1:0] DIST_LOW  = 32'sh8000_0000;
    localparam logic signed [DIST_BITS:0]   SUM_TOP   = 33'sh0_7FFF_FFFE;
    localparam logic signed [DIST_BITS:0]   SUM_LOW   = 33'sh1_8000_0000;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INIT  = 8'b0000_0010,
        S_ERD   = 8'b0000_0100,
        S_DRD   = 8'b0000_1000,
        S_SUM   = 8'b0001_0000,
        S_CMP   = 8'b0010_0000,
        S_ORD   = 8'b0100_0000,
        S_OEMIT = 8'b1000_0000
    } t_state;

endpackage

// ----- rtl/bellman_ford_shortest_paths.sv -----
`timescale 1ns / 1ps
`include "bellman_ford_shortest_paths_assert.svh"

// Channel   Direction  Handshake                  Word
// command   in         i_start / o_busy           req_type, edge_from, edge_to, edge_weight,
//                                                 start_vertex
// result    out        o_valid (strobe)           vertex_id, distance, negative_cycle, last
// config    in         i_cfg_valid / o_cfg_ready  vertex_count
//
// An edge load is one write to the edge memory.
// A run sets up nv distances, then makes nv passes over the stored edges (one
// relaxation at a time: edge read, two distance reads, add, compare and write back),
// then reads out and reports each vertex in turn; a negative cycle ends the run early.
// Reset is synchronous and active low; it empties the edge store and sets vertex_count to 64.
// Results leave one per strobe and the receiver cannot stall them.

module bellman_ford_shortest_paths #(
    parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = bfsp_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic                                  i_req_type,
    input  logic [bfsp_pkg::VID_BITS-1:0]         i_edge_from,
    input  logic [bfsp_pkg::VID_BITS-1:0]         i_edge_to,
    input  logic signed [WEIGHT_BITS-1:0]         i_edge_weight,
    input  logic [bfsp_pkg::VID_BITS-1:0]         i_start_vertex,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bfsp_pkg::CFG_BITS-1:0]         i_cfg_data,
    output logic                                  o_valid,
    output logic [bfsp_pkg::VID_BITS-1:0]         o_vertex_id,
    output logic signed [bfsp_pkg::DIST_BITS-1:0] o_distance,
    output logic                                  o_negative_cycle,
    output logic                                  o_last
);

    localparam int VB     = bfsp_pkg::VID_BITS;
    localparam int DB     = bfsp_pkg::DIST_BITS;
    localparam int NVW    = $clog2(MAX_VERTICES + 1);
    localparam int CNT_W  = (bfsp_pkg::CFG_BITS > NVW) ? bfsp_pkg::CFG_BITS : NVW;
    localparam int VA_W   = $clog2(MAX_VERTICES);
    localparam int ETOT_W = $clog2(MAX_EDGES + 1);
    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW     = 2 * VB + WEIGHT_BITS;

    localparam logic [CNT_W-1:0]  NV_MAX = CNT_W'(MAX_VERTICES);
    localparam logic [ETOT_W-1:0] E_MAX  = ETOT_W'(MAX_EDGES);

    logic [EW-1:0] r_edge_mem [MAX_EDGES];
    logic [DB-1:0] r_dist_mem [MAX_VERTICES];

    bfsp_pkg::t_state r_state;
    logic [bfsp_pkg::CFG_BITS-1:0] r_vcount;
    logic [ETOT_W-1:0]             r_edge_total;
    logic [EIDX_W-1:0]             r_j;
    logic [CNT_W-1:0]              r_nv;
    logic [CNT_W-1:0]              r_idx;
    logic [CNT_W-1:0]              r_pass;
    logic [VB-1:0]                 r_start;
    logic [EW-1:0]                 r_edge_q;
    logic signed [DB-1:0]          r_rd_a;
    logic signed [DB-1:0]          r_rd_b;
    logic                          r_skip;
    logic                          r_live;
    logic signed [DB-1:0]          r_cand;
    logic [VA_W-1:0]               r_to_a;

    logic                          r_o_valid;
    logic [VB-1:0]                 r_o_vid;
    logic signed [DB-1:0]          r_o_dist;
    logic                          r_o_neg;
    logic                          r_o_last;

    logic [CNT_W-1:0]     nv_eff;
    logic [VB-1:0]        e_from;
    logic [VB-1:0]        e_to;
    logic [WEIGHT_BITS-1:0] e_w;
    logic [CNT_W-1:0]     from_x;
    logic [CNT_W-1:0]     to_x;
    logic [CNT_W-1:0]     start_x;
    logic signed [DB:0]   sum;
    logic signed [DB-1:0] sat;
    logic                 improve;
    logic                 check_pass;
    logic                 last_edge;
    logic                 accept;

    logic                 edge_we;
    logic                 edge_re;
    logic                 dist_we;
    logic [VA_W-1:0]      dist_wa;
    logic [DB-1:0]        dist_wd;
    logic                 dist_re;
    logic [VA_W-1:0]      dist_ra_a;
    logic [VA_W-1:0]      dist_ra_b;

    assign o_busy      = (r_state != bfsp_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_comb begin
        if (r_vcount == '0) begin
            nv_eff = CNT_W'(1);
        end else if (CNT_W'(r_vcount) > NV_MAX) begin
            nv_eff = NV_MAX;
        end else begin
            nv_eff = CNT_W'(r_vcount);
        end
    end

    assign e_from  = r_edge_q[EW-1 -: VB];
    assign e_to    = r_edge_q[EW-VB-1 -: VB];
    assign e_w     = r_edge_q[WEIGHT_BITS-1:0];
    assign from_x  = CNT_W'(e_from);
    assign to_x    = CNT_W'(e_to);
    assign start_x = CNT_W'(r_start);

    assign sum = $signed({r_rd_a[DB-1], r_rd_a})
               + $signed({{(DB + 1 - WEIGHT_BITS){e_w[WEIGHT_BITS-1]}}, e_w});

    always_comb begin
        if (sum > bfsp_pkg::SUM_TOP) begin
            sat = bfsp_pkg::DIST_TOP;
        end else if (sum < bfsp_pkg::SUM_LOW) begin
            sat = bfsp_pkg::DIST_LOW;
        end else begin
            sat = sum[DB-1:0];
        end
    end

    assign improve    = r_live && (r_cand < r_rd_b);
    assign check_pass = (r_pass == r_nv - CNT_W'(1));
    assign last_edge  = (ETOT_W'(r_j) == r_edge_total - ETOT_W'(1));

    assign edge_we = accept && (i_req_type == bfsp_pkg::REQ_LOAD) && (r_edge_total < E_MAX);
    assign edge_re = (r_state == bfsp_pkg::S_ERD);

    always_comb begin
        dist_we   = 1'b0;
        dist_wa   = r_idx[VA_W-1:0];
        dist_wd   = (r_idx == start_x) ? '0 : bfsp_pkg::DIST_INF;
        dist_re   = 1'b0;
        dist_ra_a = r_idx[VA_W-1:0];
        dist_ra_b = to_x[VA_W-1:0];
        case (r_state)
            bfsp_pkg::S_INIT: begin
                dist_we = 1'b1;
            end
            bfsp_pkg::S_DRD: begin
                dist_re   = 1'b1;
                dist_ra_a = from_x[VA_W-1:0];
            end
            bfsp_pkg::S_CMP: begin
                dist_we = improve && !check_pass;
                dist_wa = r_to_a;
                dist_wd = r_cand;
            end
            bfsp_pkg::S_ORD: begin
                dist_re = 1'b1;
            end
            default: begin
                dist_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_edge_mem[r_edge_total[EIDX_W-1:0]] <= {i_edge_from, i_edge_to,
                                                    i_edge_weight};
        end
        if (edge_re) begin
            r_edge_q <= r_edge_mem[r_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            r_dist_mem[dist_wa] <= dist_wd;
        end
        if (dist_re) begin
            r_rd_a <= r_dist_mem[dist_ra_a];
            r_rd_b <= r_dist_mem[dist_ra_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bfsp_pkg::S_IDLE;
            r_vcount     <= bfsp_pkg::VCOUNT_RST;
            r_edge_total <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
            case (r_state)
                bfsp_pkg::S_IDLE: begin
                    if (accept) begin
                        if (i_req_type == bfsp_pkg::REQ_RUN) begin
                            r_start <= i_start_vertex;
                            r_nv    <= nv_eff;
                            r_idx   <= '0;
                            r_state <= bfsp_pkg::S_INIT;
                        end else if (edge_we) begin
                            r_edge_total <= r_edge_total + ETOT_W'(1);
                        end
                    end
                end
                bfsp_pkg::S_INIT: begin
                    if (r_idx == r_nv - CNT_W'(1)) begin
                        r_pass <= '0;
                        r_j    <= '0;
                        if (r_edge_total == '0) begin
                            r_idx   <= '0;
                            r_state <= bfsp_pkg::S_ORD;
                        end else begin
                            r_state <= bfsp_pkg::S_ERD;
                        end
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                bfsp_pkg::S_ERD: begin
                    r_state <= bfsp_pkg::S_DRD;
                end
                bfsp_pkg::S_DRD: begin
                    r_skip  <= (from_x >= r_nv) || (to_x >= r_nv);
                    r_to_a  <= to_x[VA_W-1:0];
                    r_state <= bfsp_pkg::S_SUM;
                end
                bfsp_pkg::S_SUM: begin
                    r_live  <= !r_skip && (r_rd_a != bfsp_pkg::DIST_INF);
                    r_cand  <= sat;
                    r_state <= bfsp_pkg::S_CMP;
                end
                bfsp_pkg::S_CMP: begin
                    if (check_pass && improve) begin
                        r_o_valid    <= 1'b1;
                        r_o_vid      <= '0;
                        r_o_dist     <= '0;
                        r_o_neg      <= 1'b1;
                        r_o_last     <= 1'b1;
                        r_edge_total <= '0;
                        r_state      <= bfsp_pkg::S_IDLE;
                    end else if (last_edge) begin
                        r_j <= '0;
                        if (check_pass) begin
                            r_idx   <= '0;
                            r_state <= bfsp_pkg::S_ORD;
                        end else begin
                            r_pass  <= r_pass + CNT_W'(1);
                            r_state <= bfsp_pkg::S_ERD;
                        end
                    end else begin
                        r_j     <= r_j + EIDX_W'(1);
                        r_state <= bfsp_pkg::S_ERD;
                    end
                end
                bfsp_pkg::S_ORD: begin
                    r_state <= bfsp_pkg::S_OEMIT;
                end
                bfsp_pkg::S_OEMIT: begin
                    r_o_valid <= 1'b1;
                    r_o_vid   <= r_idx[VB-1:0];
                    r_o_dist  <= r_rd_a;
                    r_o_neg   <= 1'b0;
                    r_o_last  <= (r_idx == r_nv - CNT_W'(1));
                    if (r_idx == r_nv - CNT_W'(1)) begin
                        r_edge_total <= '0;
                        r_state      <= bfsp_pkg::S_IDLE;
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= bfsp_pkg::S_ORD;
                    end
                end
                default: begin
                    r_state <= bfsp_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_o_valid;
    assign o_vertex_id      = r_o_vid;
    assign o_distance       = r_o_dist;
    assign o_negative_cycle = r_o_neg;
    assign o_last           = r_o_last;

    `BFSP_ASSERT_NOW(a_neg_word, o_valid && o_negative_cycle,
        o_last && (o_vertex_id == '0) && (o_distance == '0), "negative cycle word malformed")
    `BFSP_ASSERT_NOW(a_last_clears, o_valid && o_last,
        !o_busy && (r_edge_total == '0), "edge store not emptied after run")
    `BFSP_ASSERT_NOW(a_edge_idx, r_state == bfsp_pkg::S_ERD,
        ETOT_W'(r_j) < r_edge_total, "edge index past stored edges")
    `BFSP_ASSERT_NEXT(a_write_lower, dist_we && (r_state == bfsp_pkg::S_CMP),
        (r_state == bfsp_pkg::S_ERD || r_state == bfsp_pkg::S_ORD) && (r_pass < r_nv),
        "relaxation write outside an apply pass")

endmodule
